// ===== rtl/core/ps2_mouse_packet_tracker_defines.svh =====
// assertion macros for the ps2 mouse packet tracker checker
// expects signals named clock and reset in the scope of each use
`ifndef PS2_MOUSE_PACKET_TRACKER_DEFINES_SVH
`define PS2_MOUSE_PACKET_TRACKER_DEFINES_SVH

// same-cycle implication, off while reset is high
`define PS2MT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off while reset is high
`define PS2MT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// same-cycle implication that also holds around reset
`define PS2MT_ASSERT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/ps2mt_pkg.sv =====
// shared constants for the ps2 mouse packet tracker
// no dependencies
`timescale 1ns / 1ps

package ps2mt_pkg;

   localparam int COORD_BITS_DEFAULT = 12;
   localparam int EXTENT_BITS        = 13;
   localparam int OUT_COORD_BITS     = 12;
   localparam int BUTTON_BITS        = 3;
   localparam int CSR_ADDR_BITS      = 4;
   localparam int CSR_DATA_BITS      = 32;

   localparam logic [EXTENT_BITS-1:0] RESET_WIDTH  = 13'd640;
   localparam logic [EXTENT_BITS-1:0] RESET_HEIGHT = 13'd480;

   localparam logic [7:0] HEADER_SYNC_BIT = 8'h08;
   localparam logic [7:0] BUTTON_MASK     = 8'h07;

   // register index, taken from paddr[3:2]
   localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
   localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
   localparam logic [1:0] REG_ENABLED       = 2'd2;

endpackage

// ===== rtl/core/ps2mt_axis_clamp.sv =====
// one coordinate update: add or subtract a signed movement byte, then clamp
// depends on ps2mt_pkg
`timescale 1ns / 1ps

module ps2mt_axis_clamp #(
   parameter int COORD_BITS = ps2mt_pkg::COORD_BITS_DEFAULT
) (
   input  logic [COORD_BITS-1:0]            cursor_i,
   input  logic [7:0]                       delta_i,
   input  logic                             subtract_i,
   input  logic [ps2mt_pkg::EXTENT_BITS-1:0] extent_i,
   output logic [COORD_BITS-1:0]            cursor_o
);

   localparam int W = (COORD_BITS + 2 > ps2mt_pkg::EXTENT_BITS + 1) ?
                      COORD_BITS + 2 : ps2mt_pkg::EXTENT_BITS + 1;
   localparam logic [W-1:0] MAX_LIM = W'(1) << COORD_BITS;

   logic signed [W-1:0] cur_s;
   logic signed [W-1:0] dlt_s;
   logic signed [W-1:0] sum_s;
   logic [W-1:0]        ext_w;
   logic [W-1:0]        lim;
   logic [W-1:0]        res;

   always_comb begin
      cur_s = W'({1'b0, cursor_i});
      dlt_s = W'(signed'(delta_i));
      sum_s = subtract_i ? (cur_s - dlt_s) : (cur_s + dlt_s);

      // zero extent acts as one, large extents stop at the coordinate range
      ext_w = W'(extent_i);
      if (ext_w == '0) begin
         lim = W'(1);
      end else if (ext_w > MAX_LIM) begin
         lim = MAX_LIM;
      end else begin
         lim = ext_w;
      end

      if (sum_s < 0) begin
         res = '0;
      end else if (unsigned'(sum_s) >= lim) begin
         res = lim - W'(1);
      end else begin
         res = unsigned'(sum_s);
      end
   end

   assign cursor_o = res[COORD_BITS-1:0];

endmodule

// ===== rtl/core/ps2_mouse_packet_tracker.sv =====
// ps2 mouse packet tracker: one received byte per transfer, one position per packet
// a taken byte goes through the input stage, then the result register, to rsp_*
// throughput: one byte per cycle; a waiting result holds back only the last byte
// of the next packet, which then stalls the input until the result is taken
// reset clears control state, extents go to 640 x 480, block disabled,
// cursor to the middle of the reset extent
// depends on ps2mt_pkg and ps2mt_axis_clamp
`timescale 1ns / 1ps

module ps2_mouse_packet_tracker #(
   parameter int COORD_BITS = ps2mt_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [7:0]                            req_rx_byte,

   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [ps2mt_pkg::OUT_COORD_BITS-1:0]  rsp_pos_x,
   output logic [ps2mt_pkg::OUT_COORD_BITS-1:0]  rsp_pos_y,
   output logic [ps2mt_pkg::BUTTON_BITS-1:0]     rsp_button_bits,

   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [ps2mt_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [ps2mt_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [ps2mt_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                  pready
);

   localparam int OB = ps2mt_pkg::OUT_COORD_BITS;
   localparam logic [COORD_BITS-1:0] RESET_X =
      COORD_BITS'(ps2mt_pkg::RESET_WIDTH >> 1);
   localparam logic [COORD_BITS-1:0] RESET_Y =
      COORD_BITS'(ps2mt_pkg::RESET_HEIGHT >> 1);

   typedef enum logic [1:0] {
      IDX_HEADER = 2'd0,
      IDX_DX     = 2'd1,
      IDX_DY     = 2'd2
   } byte_index_type;

   // configuration registers
   logic [ps2mt_pkg::EXTENT_BITS-1:0] screen_width_ff;
   logic [ps2mt_pkg::EXTENT_BITS-1:0] screen_height_ff;
   logic                              enabled_ff;
   logic                              csr_write;
   logic [1:0]                        csr_index;

   // input stage
   logic       stage_valid_ff, stage_valid_in;
   logic [7:0] stage_byte_ff, stage_byte_in;

   // packet state
   byte_index_type          byte_index_ff, byte_index_in;
   logic [7:0]              header_byte_ff, header_byte_in;
   logic [7:0]              delta_x_byte_ff, delta_x_byte_in;
   logic [COORD_BITS-1:0]   cursor_x_ff, cursor_x_in;
   logic [COORD_BITS-1:0]   cursor_y_ff, cursor_y_in;

   // result register
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [OB-1:0]                    rsp_pos_x_ff, rsp_pos_x_in;
   logic [OB-1:0]                    rsp_pos_y_ff, rsp_pos_y_in;
   logic [ps2mt_pkg::BUTTON_BITS-1:0] rsp_button_ff, rsp_button_in;

   logic                  out_free;
   logic                  stage_final;
   logic                  stage_has_result;
   logic                  stage_advance;
   logic [COORD_BITS-1:0] next_x;
   logic [COORD_BITS-1:0] next_y;
   logic [COORD_BITS+OB-1:0] wide_x;
   logic [COORD_BITS+OB-1:0] wide_y;

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= ps2mt_pkg::RESET_WIDTH;
         screen_height_ff <= ps2mt_pkg::RESET_HEIGHT;
         enabled_ff       <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            ps2mt_pkg::REG_SCREEN_WIDTH:
               screen_width_ff <= pwdata[ps2mt_pkg::EXTENT_BITS-1:0];
            ps2mt_pkg::REG_SCREEN_HEIGHT:
               screen_height_ff <= pwdata[ps2mt_pkg::EXTENT_BITS-1:0];
            ps2mt_pkg::REG_ENABLED:
               enabled_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         ps2mt_pkg::REG_SCREEN_WIDTH:
            prdata = ps2mt_pkg::CSR_DATA_BITS'(screen_width_ff);
         ps2mt_pkg::REG_SCREEN_HEIGHT:
            prdata = ps2mt_pkg::CSR_DATA_BITS'(screen_height_ff);
         ps2mt_pkg::REG_ENABLED:
            prdata = ps2mt_pkg::CSR_DATA_BITS'(enabled_ff);
         default:
            prdata = '0;
      endcase
   end

   // ---------------- flow control ----------------
   assign out_free = !rsp_valid_ff || !rsp_stall;
   // an unexpected index three is handled as the last byte of a packet
   assign stage_final      = (byte_index_ff != IDX_HEADER) && (byte_index_ff != IDX_DX);
   assign stage_has_result = stage_valid_ff && enabled_ff && stage_final;
   assign stage_advance    = stage_valid_ff && (!stage_has_result || out_free);
   assign req_stall        = stage_valid_ff && !stage_advance;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_byte_in  = stage_byte_ff;
      if (!req_stall) begin
         stage_valid_in = req_valid;
         stage_byte_in  = req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      stage_byte_ff <= stage_byte_in;
   end

   // ---------------- coordinate update ----------------
   ps2mt_axis_clamp #(.COORD_BITS(COORD_BITS)) u_clamp_x (
      .cursor_i   (cursor_x_ff),
      .delta_i    (delta_x_byte_ff),
      .subtract_i (1'b0),
      .extent_i   (screen_width_ff),
      .cursor_o   (next_x)
   );

   // y grows downward, so the movement is subtracted
   ps2mt_axis_clamp #(.COORD_BITS(COORD_BITS)) u_clamp_y (
      .cursor_i   (cursor_y_ff),
      .delta_i    (stage_byte_ff),
      .subtract_i (1'b1),
      .extent_i   (screen_height_ff),
      .cursor_o   (next_y)
   );

   assign wide_x = {{OB{1'b0}}, next_x};
   assign wide_y = {{OB{1'b0}}, next_y};

   always_comb begin
      byte_index_in   = byte_index_ff;
      header_byte_in  = header_byte_ff;
      delta_x_byte_in = delta_x_byte_ff;
      cursor_x_in     = cursor_x_ff;
      cursor_y_in     = cursor_y_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_pos_x_in    = rsp_pos_x_ff;
      rsp_pos_y_in    = rsp_pos_y_ff;
      rsp_button_in   = rsp_button_ff;

      if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // disabled: the byte is consumed and nothing changes
      if (stage_advance && enabled_ff) begin
         unique case (byte_index_ff)
            IDX_HEADER: begin
               // drop headers without the sync bit to regain packet alignment
               if ((stage_byte_ff & ps2mt_pkg::HEADER_SYNC_BIT) != '0) begin
                  header_byte_in = stage_byte_ff;
                  byte_index_in  = IDX_DX;
               end
            end
            IDX_DX: begin
               delta_x_byte_in = stage_byte_ff;
               byte_index_in   = IDX_DY;
            end
            default: begin
               byte_index_in = IDX_HEADER;
               cursor_x_in   = next_x;
               cursor_y_in   = next_y;
               rsp_valid_in  = 1'b1;
               rsp_pos_x_in  = wide_x[OB-1:0];
               rsp_pos_y_in  = wide_y[OB-1:0];
               rsp_button_in = header_byte_ff[ps2mt_pkg::BUTTON_BITS-1:0] &
                               ps2mt_pkg::BUTTON_MASK[ps2mt_pkg::BUTTON_BITS-1:0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff   <= IDX_HEADER;
         header_byte_ff  <= '0;
         delta_x_byte_ff <= '0;
         cursor_x_ff     <= RESET_X;
         cursor_y_ff     <= RESET_Y;
         rsp_valid_ff    <= 1'b0;
      end else begin
         byte_index_ff   <= byte_index_in;
         header_byte_ff  <= header_byte_in;
         delta_x_byte_ff <= delta_x_byte_in;
         cursor_x_ff     <= cursor_x_in;
         cursor_y_ff     <= cursor_y_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      rsp_pos_x_ff  <= rsp_pos_x_in;
      rsp_pos_y_ff  <= rsp_pos_y_in;
      rsp_button_ff <= rsp_button_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pos_x       = rsp_pos_x_ff;
   assign rsp_pos_y       = rsp_pos_y_ff;
   assign rsp_button_bits = rsp_button_ff;

endmodule

// ===== rtl/core/ps2mt_checker.sv =====
// port-level checks for the ps2 mouse packet tracker, bound to the top level
// depends on ps2mt_pkg and ps2_mouse_packet_tracker_defines.svh
`timescale 1ns / 1ps
`include "ps2_mouse_packet_tracker_defines.svh"

module ps2mt_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic [ps2mt_pkg::OUT_COORD_BITS-1:0] rsp_pos_x,
   input logic [ps2mt_pkg::OUT_COORD_BITS-1:0] rsp_pos_y,
   input logic [ps2mt_pkg::BUTTON_BITS-1:0]    rsp_button_bits,
   input logic                                 pready
);

   // a held result keeps its payload
   `PS2MT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_pos_x) && $stable(rsp_pos_y) && $stable(rsp_button_bits), "result changed while stalled")

   // a new result follows the byte transfer that made it, through the input stage and then the result register
   `PS2MT_ASSERT_NOW(a_rsp_latency, $rose(rsp_valid), $past(req_valid && !req_stall, 2), "result without a matching byte transfer")

   // nothing is offered right after reset
   `PS2MT_ASSERT_ALWAYS(a_reset_empty, $past(reset) && !reset, !rsp_valid, "result offered after reset")

   // the register port never inserts wait states
   `PS2MT_ASSERT_NOW(a_pready_high, 1'b1, pready, "pready dropped")

endmodule

bind ps2_mouse_packet_tracker ps2mt_checker u_ps2mt_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_pos_x       (rsp_pos_x),
   .rsp_pos_y       (rsp_pos_y),
   .rsp_button_bits (rsp_button_bits),
   .pready          (pready)
);
